// ----- hdl/zsf_pkg.sv -----
// ---------------------------------------------------------------------------
// Zero-sum triplet finder package
// Shared widths, types and constants of the zero-sum triplet finder.
// ---------------------------------------------------------------------------
package zsf_pkg;

  localparam int unsigned MAX_ELEMENTS  = 16;
  localparam int unsigned VALUE_BITS    = 16;
  localparam int unsigned IDX_BITS      = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_BITS      = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SUM_BITS      = VALUE_BITS + 2;
  localparam int unsigned IN_DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_BITS = ((3 * VALUE_BITS + 7) / 8) * 8;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } cmp_t;

endpackage

// ----- hdl/zsf_alu.sv -----
// ---------------------------------------------------------------------------
// Zero-sum triplet finder shared compare unit
// Adds three sign-extended operands and reports whether the sum is zero or
// negative; used by both the insertion sort and the pointer sweep.
// ---------------------------------------------------------------------------
module zsf_alu (
  input  zsf_pkg::sum_t op_a_i,
  input  zsf_pkg::sum_t op_b_i,
  input  zsf_pkg::sum_t op_c_i,
  output zsf_pkg::cmp_t cmp_o
);

  zsf_pkg::sum_t sum;

  assign sum        = op_a_i + op_b_i + op_c_i;
  assign cmp_o.zero = (sum == '0);
  assign cmp_o.neg  = sum[zsf_pkg::SUM_BITS-1];

endmodule

// ----- hdl/zsf_store.sv -----
// ---------------------------------------------------------------------------
// Zero-sum triplet finder value store
// Holds the batch values with one write port and two registered read ports.
// ---------------------------------------------------------------------------
module zsf_store (
  input  logic             clk_i,
  input  logic             we_i,
  input  zsf_pkg::idx_t    waddr_i,
  input  zsf_pkg::value_t  wdata_i,
  input  zsf_pkg::idx_t    raddr_a_i,
  input  zsf_pkg::idx_t    raddr_b_i,
  output zsf_pkg::value_t  rdata_a_o,
  output zsf_pkg::value_t  rdata_b_o
);

  zsf_pkg::value_t mem [zsf_pkg::MAX_ELEMENTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- hdl/zero_sum_triplet_finder_core.sv -----
// ---------------------------------------------------------------------------
// Zero-sum triplet finder core
// Collects a batch of signed values, keeps them sorted and reports every
// zero-sum triplet found by a two-pointer sweep.
// ---------------------------------------------------------------------------
// Values arrive on the slave stream, one per request, with tlast on the final
// value of a batch. Each value is inserted into a sorted store by one shared
// compare unit, one shift step per cycle; how many steps a value takes is set
// by its insertion depth. Values beyond the store depth are dropped.
// After the final value the sweep runs, one anchor after another with a
// pointer step at a time, bound by the single compare unit and the two store
// read ports. Triplets leave on the master stream, one per request, the last
// one of a batch with tlast; tuser flags a batch without any triplet, with
// zero data. Results are held back by one so that the last one can be marked,
// and the block waits while the receiver stalls and the output register is
// full. The slave side is ready only between values and while no sweep is
// running. Reset empties the batch and the output register; no clearing pass
// is needed.
// ---------------------------------------------------------------------------
module zero_sum_triplet_finder_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_tvalid_i,
  output logic                                  s_tready_o,
  // sample_value
  input  logic [zsf_pkg::IN_DATA_BITS-1:0]      s_tdata_i,
  input  logic                                  s_tlast_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  // anchor_value, middle_value, top_value
  output logic [zsf_pkg::OUT_DATA_BITS-1:0]     m_tdata_o,
  // none_found
  output logic [0:0]                            m_tuser_o,
  output logic                                  m_tlast_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_START,
    ST_INS_CMP,
    ST_ANC_RD,
    ST_ANC_LD,
    ST_PAIR,
    ST_FINISH
  } state_e;

  state_e          state_q, state_d;
  zsf_pkg::cnt_t   cnt_q, cnt_d;
  zsf_pkg::idx_t   j_q, j_d;
  zsf_pkg::idx_t   i_q, i_d;
  zsf_pkg::idx_t   l_q, l_d;
  zsf_pkg::idx_t   r_q, r_d;
  zsf_pkg::value_t key_q, key_d;
  zsf_pkg::value_t x_q, x_d;
  logic            end_q, end_d;
  zsf_pkg::value_t pend_a_q, pend_a_d, pend_b_q, pend_b_d, pend_c_q, pend_c_d;
  logic            pend_valid_q, pend_valid_d;
  zsf_pkg::value_t out_a_q, out_a_d, out_b_q, out_b_d, out_c_q, out_c_d;
  logic            out_none_q, out_none_d;
  logic            out_last_q, out_last_d;
  logic            out_valid_q, out_valid_d;

  logic            mem_we;
  zsf_pkg::idx_t   mem_waddr;
  zsf_pkg::value_t mem_wdata;
  zsf_pkg::idx_t   raddr_a, raddr_b;
  zsf_pkg::value_t rdata_a, rdata_b;
  zsf_pkg::sum_t   op_a, op_b, op_c;
  zsf_pkg::cmp_t   cmp;

  logic            out_free;
  logic            s_accept;
  zsf_pkg::idx_t   l_n, r_n, i_n;
  zsf_pkg::cnt_t   n_ins;

  zsf_store u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  zsf_alu u_alu (
    .op_a_i (op_a),
    .op_b_i (op_b),
    .op_c_i (op_c),
    .cmp_o  (cmp)
  );

  assign s_tready_o = (state_q == ST_IDLE);
  assign s_accept   = s_tvalid_i && s_tready_o;
  assign out_free   = !out_valid_q || m_tready_i;
  assign n_ins      = cnt_q + zsf_pkg::cnt_t'(1);

  always_comb begin
    if (state_q == ST_INS_CMP) begin
      op_a = zsf_pkg::sum_t'(key_q);
      op_b = -zsf_pkg::sum_t'(rdata_a);
      op_c = '0;
    end else begin
      op_a = zsf_pkg::sum_t'(x_q);
      op_b = zsf_pkg::sum_t'(rdata_a);
      op_c = zsf_pkg::sum_t'(rdata_b);
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    j_d          = j_q;
    i_d          = i_q;
    l_d          = l_q;
    r_d          = r_q;
    key_d        = key_q;
    x_d          = x_q;
    end_d        = end_q;
    pend_a_d     = pend_a_q;
    pend_b_d     = pend_b_q;
    pend_c_d     = pend_c_q;
    pend_valid_d = pend_valid_q;
    out_a_d      = out_a_q;
    out_b_d      = out_b_q;
    out_c_d      = out_c_q;
    out_none_d   = out_none_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q;
    mem_we       = 1'b0;
    mem_waddr    = j_q;
    mem_wdata    = key_q;
    raddr_a      = l_q;
    raddr_b      = r_q;
    l_n          = l_q;
    r_n          = r_q;
    i_n          = i_q + zsf_pkg::idx_t'(1);

    if (out_valid_q && m_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          end_d = s_tlast_i;
          key_d = zsf_pkg::value_t'(s_tdata_i[zsf_pkg::VALUE_BITS-1:0]);
          j_d   = cnt_q[zsf_pkg::IDX_BITS-1:0];
          if (cnt_q < zsf_pkg::cnt_t'(zsf_pkg::MAX_ELEMENTS)) begin
            state_d = ST_INS_START;
          end else if (s_tlast_i) begin
            i_d     = '0;
            state_d = ST_ANC_RD;
          end
        end
      end
      ST_INS_START: begin
        if (j_q == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = key_q;
          cnt_d     = n_ins;
          if (!end_q) begin
            state_d = ST_IDLE;
          end else if (n_ins < zsf_pkg::cnt_t'(3)) begin
            state_d = ST_FINISH;
          end else begin
            i_d     = '0;
            state_d = ST_ANC_RD;
          end
        end else begin
          raddr_a = j_q - zsf_pkg::idx_t'(1);
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        if (cmp.neg) begin
          mem_wdata = rdata_a;
          j_d       = j_q - zsf_pkg::idx_t'(1);
          if (j_q == zsf_pkg::idx_t'(1)) begin
            state_d = ST_INS_START;
          end else begin
            raddr_a = j_q - zsf_pkg::idx_t'(2);
          end
        end else begin
          mem_wdata = key_q;
          cnt_d     = n_ins;
          if (!end_q) begin
            state_d = ST_IDLE;
          end else if (n_ins < zsf_pkg::cnt_t'(3)) begin
            state_d = ST_FINISH;
          end else begin
            i_d     = '0;
            state_d = ST_ANC_RD;
          end
        end
      end
      ST_ANC_RD: begin
        raddr_a = i_q;
        state_d = ST_ANC_LD;
      end
      ST_ANC_LD: begin
        x_d     = rdata_a;
        l_d     = i_q + zsf_pkg::idx_t'(1);
        r_d     = zsf_pkg::idx_t'(cnt_q - zsf_pkg::cnt_t'(1));
        raddr_a = l_d;
        raddr_b = r_d;
        state_d = ST_PAIR;
      end
      ST_PAIR: begin
        if (!(cmp.zero && pend_valid_q && !out_free)) begin
          if (cmp.zero) begin
            if (pend_valid_q) begin
              out_a_d     = pend_a_q;
              out_b_d     = pend_b_q;
              out_c_d     = pend_c_q;
              out_none_d  = 1'b0;
              out_last_d  = 1'b0;
              out_valid_d = 1'b1;
            end
            pend_a_d     = x_q;
            pend_b_d     = rdata_a;
            pend_c_d     = rdata_b;
            pend_valid_d = 1'b1;
            l_n          = l_q + zsf_pkg::idx_t'(1);
            r_n          = r_q - zsf_pkg::idx_t'(1);
          end else if (cmp.neg) begin
            l_n = l_q + zsf_pkg::idx_t'(1);
          end else begin
            r_n = r_q - zsf_pkg::idx_t'(1);
          end
          if (l_n < r_n) begin
            l_d     = l_n;
            r_d     = r_n;
            raddr_a = l_n;
            raddr_b = r_n;
          end else if ((zsf_pkg::cnt_t'(i_n) + zsf_pkg::cnt_t'(2)) < cnt_q) begin
            i_d     = i_n;
            raddr_a = i_n;
            state_d = ST_ANC_LD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          if (pend_valid_q) begin
            out_a_d    = pend_a_q;
            out_b_d    = pend_b_q;
            out_c_d    = pend_c_q;
            out_none_d = 1'b0;
          end else begin
            out_a_d    = '0;
            out_b_d    = '0;
            out_c_d    = '0;
            out_none_d = 1'b1;
          end
          pend_valid_d = 1'b0;
          cnt_d        = '0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      j_q          <= '0;
      i_q          <= '0;
      l_q          <= '0;
      r_q          <= '0;
      key_q        <= '0;
      x_q          <= '0;
      end_q        <= 1'b0;
      pend_a_q     <= '0;
      pend_b_q     <= '0;
      pend_c_q     <= '0;
      pend_valid_q <= 1'b0;
      out_a_q      <= '0;
      out_b_q      <= '0;
      out_c_q      <= '0;
      out_none_q   <= 1'b0;
      out_last_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      j_q          <= j_d;
      i_q          <= i_d;
      l_q          <= l_d;
      r_q          <= r_d;
      key_q        <= key_d;
      x_q          <= x_d;
      end_q        <= end_d;
      pend_a_q     <= pend_a_d;
      pend_b_q     <= pend_b_d;
      pend_c_q     <= pend_c_d;
      pend_valid_q <= pend_valid_d;
      out_a_q      <= out_a_d;
      out_b_q      <= out_b_d;
      out_c_q      <= out_c_d;
      out_none_q   <= out_none_d;
      out_last_q   <= out_last_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = zsf_pkg::OUT_DATA_BITS'({out_c_q, out_b_q, out_a_q});
  assign m_tuser_o  = out_none_q;
  assign m_tlast_o  = out_last_q;

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAIR) |-> (l_q < r_q))
    else $error("Pointer sweep running with crossed pointers.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= zsf_pkg::cnt_t'(zsf_pkg::MAX_ELEMENTS))
    else $error("Stored count exceeds the store depth.");

  a_none_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o[0]) |-> (m_tlast_o && (m_tdata_o == '0)))
    else $error("Empty-batch result is not a zero final result.");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !pend_valid_q)
    else $error("Held-back triplet left over while taking new values.");

  a_insert_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_CMP) |-> (j_q != '0))
    else $error("Insertion compare at the bottom of the store.");

endmodule

// ----- test/zsf_checker.sv -----
// ---------------------------------------------------------------------------
// Zero-sum triplet finder checker
// Watches both streams of the core, collects each accepted batch, works out
// the zero-sum triplets that the batch must give and compares every result
// request with the oldest one still expected.
// ---------------------------------------------------------------------------
module zsf_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_tvalid_i,
  input  logic                              s_tready_i,
  input  logic [zsf_pkg::IN_DATA_BITS-1:0]  s_tdata_i,
  input  logic                              s_tlast_i,
  input  logic                              m_tvalid_i,
  input  logic                              m_tready_i,
  input  logic [zsf_pkg::OUT_DATA_BITS-1:0] m_tdata_i,
  input  logic [0:0]                        m_tuser_i,
  input  logic                              m_tlast_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TRIPLETS = 56;

  typedef struct packed {
    zsf_pkg::value_t anchor;
    zsf_pkg::value_t middle;
    zsf_pkg::value_t top;
    logic            none;
    logic            last;
  } triplet_t;

  zsf_pkg::value_t batch_vals [zsf_pkg::MAX_ELEMENTS];
  int              batch_len = 0;
  triplet_t        triplet_q [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic void find_triplets();
    zsf_pkg::value_t sorted [zsf_pkg::MAX_ELEMENTS];
    zsf_pkg::value_t key;
    triplet_t        found [$];
    triplet_t        t;
    int              i;
    int              j;
    int              l;
    int              r;
    int              total;
    for (i = 0; i < zsf_pkg::MAX_ELEMENTS; i++) sorted[i] = batch_vals[i];
    for (i = 1; i < batch_len; i++) begin
      key = sorted[i];
      j   = i;
      while (j > 0 && sorted[j-1] > key) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = key;
    end
    for (i = 0; i + 2 < batch_len; i++) begin
      l = i + 1;
      r = batch_len - 1;
      while (l < r) begin
        total = int'(sorted[i]) + int'(sorted[l]) + int'(sorted[r]);
        if (total == 0) begin
          if (found.size() < MAX_TRIPLETS) begin
            t = '{sorted[i], sorted[l], sorted[r], 1'b0, 1'b0};
            found.push_back(t);
          end
          l++;
          r--;
        end else if (total < 0) begin
          l++;
        end else begin
          r--;
        end
      end
    end
    if (found.size() == 0) begin
      t = '{zsf_pkg::value_t'(0), zsf_pkg::value_t'(0), zsf_pkg::value_t'(0), 1'b1, 1'b0};
      found.push_back(t);
    end
    t      = found.pop_back();
    t.last = 1'b1;
    found.push_back(t);
    foreach (found[k]) triplet_q.push_back(found[k]);
  endfunction

  function automatic int field_differs(string name, int want, int got);
    if (want != got) begin
      $display("%0t: mismatch in %s, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    triplet_t want;
    triplet_t got;
    if (rst_ni && s_tvalid_i && s_tready_i) begin
      if (batch_len < zsf_pkg::MAX_ELEMENTS) begin
        batch_vals[batch_len] = zsf_pkg::value_t'(s_tdata_i[zsf_pkg::VALUE_BITS-1:0]);
        batch_len++;
      end
      if (s_tlast_i) begin
        find_triplets();
        batch_len = 0;
      end
    end
    if (rst_ni && m_tvalid_i && m_tready_i) begin
      got = '{zsf_pkg::value_t'(m_tdata_i[zsf_pkg::VALUE_BITS-1:0]),
              zsf_pkg::value_t'(m_tdata_i[2*zsf_pkg::VALUE_BITS-1:zsf_pkg::VALUE_BITS]),
              zsf_pkg::value_t'(m_tdata_i[3*zsf_pkg::VALUE_BITS-1:2*zsf_pkg::VALUE_BITS]),
              m_tuser_i[0], m_tlast_i};
      if (triplet_q.size() == 0) begin
        $display("%0t: result request with none expected, actual %0d %0d %0d none %0b last %0b",
                 $time, got.anchor, got.middle, got.top, got.none, got.last);
        fail_count_o++;
      end else begin
        want = triplet_q.pop_front();
        fail_count_o += field_differs("anchor_value", int'(want.anchor), int'(got.anchor));
        fail_count_o += field_differs("middle_value", int'(want.middle), int'(got.middle));
        fail_count_o += field_differs("top_value", int'(want.top), int'(got.top));
        fail_count_o += field_differs("none_found", int'(want.none), int'(got.none));
        fail_count_o += field_differs("run_end", int'(want.last), int'(got.last));
      end
    end
    pending_o = triplet_q.size();
  end

endmodule

// ----- test/tb.sv -----
// ---------------------------------------------------------------------------
// Zero-sum triplet finder testbench
// Sends directed and random batches of signed values to the core, with random
// gaps on the input and random stalls on the output until the last random
// batches, lets the checker compare every result request, and reports the verdict.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 110;
  localparam int CALM_AFTER   = 85;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic                              clk_i    = 1'b0;
  logic                              rst_ni   = 1'b0;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [zsf_pkg::IN_DATA_BITS-1:0]  s_tdata  = '0;
  logic                              s_tlast  = 1'b0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [zsf_pkg::OUT_DATA_BITS-1:0] m_tdata;
  logic [0:0]                        m_tuser;
  logic                              m_tlast;

  int              fail_count;
  int              pending;
  int              stall_cycles = 0;
  bit              idling       = 1'b1;
  zsf_pkg::value_t batch_q [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  zero_sum_triplet_finder_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .m_tlast_o  (m_tlast)
  );

  zsf_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  task automatic send_batch();
    int n;
    n = batch_q.size();
    for (int i = 0; i < n; i++) begin
      if (idling && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= zsf_pkg::IN_DATA_BITS'(batch_q[i]);
      s_tlast  <= (i == n - 1);
      do @(posedge clk_i); while (!s_tready);
    end
  endtask

  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (idling && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("zero_sum_triplet_finder_core test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int n;
    int a;
    int b;
    int kind;
    int sent;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A single value, two extreme values, and an extreme triplet.
    batch_q = {zsf_pkg::value_t'(5)};
    send_batch();
    batch_q = {zsf_pkg::value_t'(32767), zsf_pkg::value_t'(-32768)};
    send_batch();
    batch_q = {zsf_pkg::value_t'(-32768), zsf_pkg::value_t'(32767), zsf_pkg::value_t'(1)};
    send_batch();
    // Repeated values give repeated triplets; the last batch gives none.
    batch_q = {zsf_pkg::value_t'(1), zsf_pkg::value_t'(-2), zsf_pkg::value_t'(1),
               zsf_pkg::value_t'(1), zsf_pkg::value_t'(1)};
    send_batch();
    batch_q = {zsf_pkg::value_t'(0), zsf_pkg::value_t'(0), zsf_pkg::value_t'(0),
               zsf_pkg::value_t'(0)};
    send_batch();
    batch_q = {zsf_pkg::value_t'(1), zsf_pkg::value_t'(2), zsf_pkg::value_t'(3)};
    send_batch();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idling = (sent < CALM_AFTER);
      n = $urandom_range(1, 12);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(13, 16);
      if ($urandom_range(0, 11) == 0) n = $urandom_range(17, 20);
      kind = $urandom_range(0, 9);
      batch_q.delete();
      while (batch_q.size() < n) begin
        if (kind < 6) begin
          batch_q.push_back(zsf_pkg::value_t'(int'($urandom_range(0, 16)) - 8));
        end else if (kind < 8 && n - batch_q.size() >= 3 && $urandom_range(0, 1)) begin
          a = int'($urandom_range(0, 32767)) - 16384;
          b = int'($urandom_range(0, 32767)) - 16384;
          batch_q.push_back(zsf_pkg::value_t'(a));
          batch_q.push_back(zsf_pkg::value_t'(-(a + b)));
          batch_q.push_back(zsf_pkg::value_t'(b));
        end else begin
          batch_q.push_back(zsf_pkg::value_t'($urandom));
        end
      end
      send_batch();
      sent += batch_q.size();
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("zero_sum_triplet_finder_core test passed");
    end else begin
      $display("zero_sum_triplet_finder_core test failed");
    end
    $finish;
  end

endmodule
